// ===== sv/spq_pkg.sv =====
// Package for the stable priority queue: word structs, operation and
// status codes, cell select codes and the default capacity.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OCC_W        = 5;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_LIST  = 2'd1;
    localparam logic [1:0] OP_SERVE = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    localparam logic [2:0] STAT_ADDED  = 3'd0;
    localparam logic [2:0] STAT_FULL   = 3'd1;
    localparam logic [2:0] STAT_SERVED = 3'd2;
    localparam logic [2:0] STAT_NONE   = 3'd3;
    localparam logic [2:0] STAT_LISTED = 3'd4;
    localparam logic [2:0] STAT_EMPTY  = 3'd5;
    localparam logic [2:0] STAT_COUNT  = 3'd6;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_LOAD = 2'd1;
    localparam logic [1:0] CELL_NEXT = 2'd2;
    localparam logic [1:0] CELL_HEAD = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] patient_id;
        logic [7:0]  age;
        logic [1:0]  priority_req;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [15:0]      out_id;
        logic [7:0]       out_age;
        logic [1:0]       out_priority;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  age;
        logic [1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic       valid;
        logic [1:0] max_prio;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
// One queue cell: holds one entry, loads a new word, its upper
// neighbor or the head, and flags a match on the served priority level.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire                 i_clk,
    input  wire [1:0]           i_sel,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_next,
    input  spq_pkg::t_entry     i_head,
    output spq_pkg::t_entry     o_entry,
    output logic                o_match
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    always_comb begin
        case (i_sel)
            spq_pkg::CELL_HOLD: n_entry = r_entry;
            spq_pkg::CELL_LOAD: n_entry = i_new;
            spq_pkg::CELL_NEXT: n_entry = i_next;
            spq_pkg::CELL_HEAD: n_entry = i_head;
            default:            n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = i_ctrl.valid && (r_entry.prio == i_ctrl.max_prio);

endmodule

`default_nettype wire

// ===== sv/stable_priority_queue.sv =====
// Stable priority queue top level: control sequencer, output register
// and the chain of spq_cell entries. Depends on spq_pkg and spq_cell.
//
// Entries sit in a chain of CAPACITY cells in arrival order, the oldest in
// cell 0. Add, count, full, empty-serve and empty-list words reach the
// output register in the cycle after acceptance. Serve first registers
// the highest held priority level; once the output register is free, the
// first cell on that level is picked, output, and the cells above it shift
// down one place. List then outputs the entry in cell 0 whenever the output
// register is free, rotating the chain through cell 0 once, ending in its
// original order. A new input word is taken when the sequencer is idle and
// the output register is free or being drained in the same cycle.
`default_nettype none

module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output spq_pkg::t_out o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SERVE = 2'd1;
    localparam logic [1:0] S_LIST  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_max, n_max;
    logic             r_out_valid, n_out_valid;
    spq_pkg::t_out    r_out, n_out;

    spq_pkg::t_entry     w_entry [CAPACITY];
    spq_pkg::t_cell_ctrl w_ctrl  [CAPACITY];
    logic [1:0]          w_sel   [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_after;
    logic [CAPACITY-1:0] w_first;
    logic [3:0]          w_has;
    logic [1:0]          w_top;
    logic                w_free;
    logic                w_acc;
    logic                w_list_last;
    spq_pkg::t_entry     w_new;
    spq_pkg::t_entry     w_pick;
    logic [CNT_W-1:0]    w_count_dec;

    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_free;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_count_dec = r_count - CNT_W'(1);
    assign w_list_last = (CNT_W'(r_idx) == w_count_dec);

    assign w_new.id   = i_in_data.patient_id;
    assign w_new.age  = i_in_data.age;
    assign w_new.prio = i_in_data.priority_req;

    // highest priority level among held entries
    always_comb begin
        w_has = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i]         = (CNT_W'(i) < r_count);
            w_ctrl[i].valid    = w_valid[i];
            w_ctrl[i].max_prio = r_max;
            if (w_valid[i]) begin
                w_has[w_entry[i].prio] = 1'b1;
            end
        end
        if (w_has[3]) begin
            w_top = 2'd3;
        end else if (w_has[2]) begin
            w_top = 2'd2;
        end else if (w_has[1]) begin
            w_top = 2'd1;
        end else begin
            w_top = 2'd0;
        end
    end

    // first cell on the served level, and the cells at or above it
    always_comb begin
        w_after[0] = w_match[0];
        w_first[0] = w_match[0];
        w_pick     = w_match[0] ? w_entry[0] : '0;
        for (int i = 1; i < CAPACITY; i++) begin
            w_after[i] = w_match[i] || w_after[i-1];
            w_first[i] = w_match[i] && !w_after[i-1];
            if (w_first[i]) begin
                w_pick = w_pick | w_entry[i];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_max       = r_max;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel[i] = spq_pkg::CELL_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out             = '0;
                    n_out.last        = 1'b1;
                    n_out.occupancy   = spq_pkg::OCC_W'(r_count);
                    n_out_valid       = 1'b1;
                    case (i_in_data.operation)
                        spq_pkg::OP_ADD: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_out.status = spq_pkg::STAT_FULL;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (CNT_W'(i) == r_count) begin
                                        w_sel[i] = spq_pkg::CELL_LOAD;
                                    end
                                end
                                n_count         = r_count + CNT_W'(1);
                                n_out.status    = spq_pkg::STAT_ADDED;
                                n_out.occupancy = spq_pkg::OCC_W'(n_count);
                            end
                        end
                        spq_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_out.status = spq_pkg::STAT_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                n_idx       = '0;
                                n_state     = S_LIST;
                            end
                        end
                        spq_pkg::OP_SERVE: begin
                            if (r_count == '0) begin
                                n_out.status = spq_pkg::STAT_NONE;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                n_max       = w_top;
                                n_state     = S_SERVE;
                            end
                        end
                        spq_pkg::OP_COUNT: begin
                            n_out.status = spq_pkg::STAT_COUNT;
                        end
                        default: begin
                            n_out.status = spq_pkg::STAT_COUNT;
                        end
                    endcase
                end
            end
            S_SERVE: begin
                if (w_free) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_after[i]) begin
                            w_sel[i] = spq_pkg::CELL_NEXT;
                        end
                    end
                    n_count            = w_count_dec;
                    n_out.status       = spq_pkg::STAT_SERVED;
                    n_out.out_id       = w_pick.id;
                    n_out.out_age      = w_pick.age;
                    n_out.out_priority = w_pick.prio;
                    n_out.occupancy    = spq_pkg::OCC_W'(w_count_dec);
                    n_out.last         = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_free) begin
                    // rotate the held entries through the head
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CNT_W'(i) == w_count_dec) begin
                            w_sel[i] = spq_pkg::CELL_HEAD;
                        end else if (w_valid[i]) begin
                            w_sel[i] = spq_pkg::CELL_NEXT;
                        end
                    end
                    n_out.status       = spq_pkg::STAT_LISTED;
                    n_out.out_id       = w_entry[0].id;
                    n_out.out_age      = w_entry[0].age;
                    n_out.out_priority = w_entry[0].prio;
                    n_out.occupancy    = spq_pkg::OCC_W'(r_count);
                    n_out.last         = w_list_last;
                    n_out_valid        = 1'b1;
                    n_idx              = r_idx + IDX_W'(1);
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[g]),
            .i_ctrl  (w_ctrl[g]),
            .i_new   (w_new),
            .i_next  (w_entry[(g < CAPACITY - 1) ? g + 1 : g]),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_serve_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE) |-> (r_count != '0))
        else $error("serve pending on an empty queue");

    a_serve_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE) |-> $onehot(w_first))
        else $error("serve must pick exactly one cell");

    a_list_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (CNT_W'(r_idx) < r_count))
        else $error("list index past held entries");

    a_served_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE && w_free) |=> (r_count == $past(w_count_dec)))
        else $error("serve must drop exactly one entry");

endmodule

`default_nettype wire
